### hw/rtl/x86d_pkg.sv
package x86d_pkg;

    localparam logic [2:0] PH_PREFIX = 3'd0;
    localparam logic [2:0] PH_OPC    = 3'd1;
    localparam logic [2:0] PH_ESC    = 3'd2;
    localparam logic [2:0] PH_ESC2   = 3'd3;
    localparam logic [2:0] PH_MODRM  = 3'd4;
    localparam logic [2:0] PH_SIB    = 3'd5;
    localparam logic [2:0] PH_DISP   = 3'd6;
    localparam logic [2:0] PH_IMM    = 3'd7;

    localparam logic [2:0] DT_BYTE  = 3'd0;
    localparam logic [2:0] DT_WORD  = 3'd1;
    localparam logic [2:0] DT_DWORD = 3'd2;
    localparam logic [2:0] DT_QWORD = 3'd3;
    localparam logic [2:0] DT_F32X1 = 3'd4;
    localparam logic [2:0] DT_F64X1 = 3'd5;
    localparam logic [2:0] DT_F32X4 = 3'd6;
    localparam logic [2:0] DT_F64X2 = 3'd7;

    localparam logic [2:0] SEG_NONE = 3'd0;
    localparam logic [2:0] SEG_CS   = 3'd1;
    localparam logic [2:0] SEG_SS   = 3'd2;
    localparam logic [2:0] SEG_DS   = 3'd3;
    localparam logic [2:0] SEG_ES   = 3'd4;
    localparam logic [2:0] SEG_FS   = 3'd5;
    localparam logic [2:0] SEG_GS   = 3'd6;

    typedef struct packed {
        logic scalar;
        logic sse;
        logic rax;
        logic rcx;
        logic twodt;
        logic noarg;
        logic group;
        logic plusr;
        logic is64;
        logic is8;
        logic imm8;
        logic imm;
        logic dir;
        logic modrm;
    } props_t;

    // last member sits in the lowest bits
    typedef struct packed {
        logic [5:0]  inst_length;
        logic [2:0]  segment;
        logic [5:0]  inst_flags;
        logic [63:0] immediate;
        logic [5:0]  disp_offset;
        logic [31:0] displacement;
        logic [1:0]  scale_log2;
        logic [23:0] reg_fields;
        logic [2:0]  second_type;
        logic [2:0]  data_type;
        logic [14:0] ext_opcode;
        logic        status;
    } result_t;

    function automatic props_t mk(input int modrm, input int dir, input int imm,
                                  input int imm8, input int is8, input int is64,
                                  input int plusr, input int group,
                                  input int noarg, input int twodt,
                                  input int rcx, input int rax, input int sse,
                                  input int scalar);
        props_t p;
        p = '{1'(scalar), 1'(sse), 1'(rax), 1'(rcx), 1'(twodt), 1'(noarg), 1'(group),
              1'(plusr), 1'(is64), 1'(is8), 1'(imm8), 1'(imm), 1'(dir), 1'(modrm)};
        return p;
    endfunction

    function automatic props_t rom(input logic [9:0] op);
        props_t     p;
        logic [7:0] o;
        p = '0;
        o = op[7:0];
        if (op[9:8] == 2'd0) begin
            if (o < 8'h40 && o[7:3] != 5'd3) begin
                unique case (o[2:0])
                    3'd0: p = mk(1,0,0,0,1,0,0,0,0,0,0,0,0,0);
                    3'd1: p = mk(1,0,0,0,0,0,0,0,0,0,0,0,0,0);
                    3'd2: p = mk(1,1,0,0,1,0,0,0,0,0,0,0,0,0);
                    3'd3: p = mk(1,1,0,0,0,0,0,0,0,0,0,0,0,0);
                    3'd4: p = mk(0,0,0,1,0,0,0,0,0,0,0,1,0,0);
                    3'd5: p = mk(0,0,1,0,0,0,0,0,0,0,0,1,0,0);
                    default: p = '0;
                endcase
            end else if (o >= 8'h50 && o <= 8'h5f) begin
                p = mk(0,0,0,0,0,1,1,0,0,0,0,0,0,0);
            end else if (o >= 8'h70 && o <= 8'h7f) begin
                p = mk(0,0,0,1,0,0,0,0,0,0,0,0,0,0);
            end else if (o >= 8'hb0 && o <= 8'hb7) begin
                p = mk(0,0,1,0,1,0,1,0,0,0,0,0,0,0);
            end else if (o >= 8'hb8 && o <= 8'hbf) begin
                p = mk(0,0,1,0,0,0,1,0,0,0,0,0,0,0);
            end else begin
                unique case (o)
                    8'h88, 8'h84: p = mk(1,0,0,0,1,0,0,0,0,0,0,0,0,0);
                    8'h89, 8'h85: p = mk(1,0,0,0,0,0,0,0,0,0,0,0,0,0);
                    8'h8a: p = mk(1,1,0,0,1,0,0,0,0,0,0,0,0,0);
                    8'h8b, 8'h8d: p = mk(1,1,0,0,0,0,0,0,0,0,0,0,0,0);
                    8'h63: p = mk(1,1,0,0,0,0,0,0,0,1,0,0,0,0);
                    8'h69: p = mk(1,1,1,0,0,0,0,0,0,0,0,0,0,0);
                    8'h80, 8'hc6: p = mk(1,0,1,0,1,0,0,1,0,0,0,0,0,0);
                    8'h81, 8'hc7: p = mk(1,0,1,0,0,0,0,1,0,0,0,0,0,0);
                    8'h83, 8'hc1: p = mk(1,0,0,1,0,0,0,1,0,0,0,0,0,0);
                    8'hc0: p = mk(1,0,0,1,1,0,0,1,0,0,0,0,0,0);
                    8'h90, 8'h98, 8'h99, 8'hc3, 8'h9c, 8'h9d, 8'ha4, 8'ha5, 8'haa,
                    8'hab, 8'hae, 8'haf, 8'hcc: p = mk(0,0,0,0,0,0,0,0,1,0,0,0,0,0);
                    8'hd0, 8'hf6: p = mk(1,0,0,0,1,0,0,1,0,0,0,0,0,0);
                    8'hd1, 8'hf7, 8'hfe, 8'hff: p = mk(1,0,0,0,0,0,0,1,0,0,0,0,0,0);
                    8'hd2: p = mk(1,0,0,0,1,0,0,1,0,0,1,0,0,0);
                    8'hd3: p = mk(1,0,0,0,0,0,0,1,0,0,1,0,0,0);
                    8'he8, 8'he9: p = mk(0,0,1,0,0,0,0,0,0,0,0,0,0,0);
                    8'heb: p = mk(0,0,0,1,0,0,0,0,0,0,0,0,0,0);
                    default: p = '0;
                endcase
            end
        end else if (op[9:8] == 2'd1) begin
            if (o >= 8'hc8 && o <= 8'hcf) p = mk(0,0,0,0,0,0,1,0,0,0,0,0,0,0);
            else if (o >= 8'h40 && o <= 8'h4f) p = mk(1,1,0,0,0,0,0,0,0,0,0,0,0,0);
            else if (o >= 8'h51 && o <= 8'h5f) p = mk(1,1,0,0,0,0,0,0,0,0,0,0,1,0);
            else if (o >= 8'h80 && o <= 8'h8f) p = mk(0,0,1,0,0,0,0,0,0,0,0,0,0,0);
            else if (o >= 8'h90 && o <= 8'h9f) p = mk(1,0,0,0,0,0,0,1,0,0,0,0,0,0);
            else begin
                unique case (o)
                    8'h05, 8'h0b: p = mk(0,0,0,0,0,0,0,0,1,0,0,0,0,0);
                    8'h10: p = mk(1,1,0,0,0,0,0,0,0,0,0,0,1,0);
                    8'h11: p = mk(1,0,0,0,0,0,0,0,0,0,0,0,1,0);
                    8'h1f, 8'ha3, 8'haf: p = mk(1,0,0,0,0,0,0,0,0,0,0,0,0,0);
                    8'h2e: p = mk(1,1,0,0,0,0,0,0,0,0,0,0,1,1);
                    8'hc6: p = mk(1,1,0,1,0,0,0,0,0,0,0,0,1,0);
                    8'hb6, 8'hb7, 8'hbe, 8'hbf: p = mk(1,1,0,0,0,0,0,0,0,1,0,0,0,0);
                    default: p = '0;
                endcase
            end
        end
        return p;
    endfunction

endpackage

### hw/rtl/x86_64_instruction_decoder_top.sv
// result word: registered, valid in the cycle after the last byte of an instruction is taken
// throughput: one byte per cycle, results held in an output register
// a stalled result blocks new bytes only while the output register is full
// reset (asynchronous, rst_n low): decoder returns to the prefix phase, no result
// each result word returns all decode state to its reset values
module x86_64_instruction_decoder_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // instr_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, ext_opcode, data_type, second_type, reg_fields, scale_log2,
    // displacement, disp_offset, immediate, inst_flags, segment, inst_length
    output logic [167:0] m_tdata
);
    import x86d_pkg::*;

    logic [2:0]  phase_reg, phase_next;
    logic [2:0]  pflags_reg, pflags_next;
    logic [2:0]  otype_reg, otype_next;
    logic [2:0]  seg_reg, seg_next;
    logic [3:0]  rex_reg, rex_next;
    logic [14:0] opc_reg, opc_next;
    props_t      prop_reg, prop_next;
    logic [1:0]  mod_reg, mod_next;
    logic [23:0] racc_reg, racc_next;
    logic [31:0] disp_reg, disp_next;
    logic [63:0] imm_reg, imm_next;
    logic [3:0]  left_reg, left_next;
    logic [3:0]  fsize_reg, fsize_next;
    logic [5:0]  cnt_reg;
    logic [5:0]  dpos_reg, dpos_next;
    logic [1:0]  scale_reg, scale_next;
    logic        ind_reg, ind_next;
    logic        hasimm_reg, hasimm_next;
    logic        out_v_reg;
    result_t     out_reg, res;

    logic        take, fire, err, clr;
    logic [7:0]  b;
    logic [5:0]  cnt;
    logic [9:0]  op;
    props_t      p;
    logic        go_imm, go_disp, do_op;
    logic [3:0]  dn, isz;
    logic [2:0]  sh;
    logic [63:0] imm_fin;
    logic [31:0] disp_cur;
    logic [4:0]  idx;
    logic [7:0]  base;
    logic [2:0]  dt2;

    assign s_tready = !out_v_reg || m_tready;
    assign take = s_tvalid && s_tready;
    assign b = s_tdata;
    assign cnt = (cnt_reg == 6'd63) ? cnt_reg : cnt_reg + 6'd1;
    assign m_tvalid = out_v_reg;
    assign m_tdata = {3'd0, out_reg};

    always_comb
    begin
        phase_next = phase_reg; pflags_next = pflags_reg; otype_next = otype_reg;
        seg_next = seg_reg; rex_next = rex_reg; opc_next = opc_reg; prop_next = prop_reg;
        mod_next = mod_reg; racc_next = racc_reg; disp_next = disp_reg;
        imm_next = imm_reg; left_next = left_reg; fsize_next = fsize_reg;
        dpos_next = dpos_reg; scale_next = scale_reg; ind_next = ind_reg;
        hasimm_next = hasimm_reg;
        fire = 1'b0; err = 1'b0; go_imm = 1'b0; go_disp = 1'b0; do_op = 1'b0;
        dn = 4'd0; op = 10'd0; p = '0; idx = 5'd0; base = 8'd0; sh = 3'd0;
        imm_fin = imm_reg;
        unique case (phase_reg)
            PH_PREFIX:
            begin
                unique case (b)
                    8'hf0: pflags_next[0] = 1'b1;
                    8'hf3: pflags_next[1] = 1'b1;
                    8'hf2: pflags_next[2] = 1'b1;
                    8'h66: otype_next = DT_WORD;
                    8'h67: ;
                    8'h2e: seg_next = SEG_CS;
                    8'h36: seg_next = SEG_SS;
                    8'h3e: seg_next = SEG_DS;
                    8'h26: seg_next = SEG_ES;
                    8'h64: seg_next = SEG_FS;
                    8'h65: seg_next = SEG_GS;
                    default:
                    begin
                        if (b[7:4] == 4'h4)
                        begin
                            rex_next = b[3:0];
                            phase_next = PH_OPC;
                        end
                        else if (b == 8'h0f) phase_next = PH_ESC;
                        else
                        begin
                            do_op = 1'b1; op = {2'd0, b};
                        end
                    end
                endcase
            end
            PH_OPC:
            begin
                if (b == 8'h0f) phase_next = PH_ESC;
                else
                begin
                    do_op = 1'b1; op = {2'd0, b};
                end
            end
            PH_ESC:
            begin
                if (b == 8'h38)
                begin
                    opc_next = 15'h200; phase_next = PH_ESC2;
                end
                else if (b == 8'h3a)
                begin
                    opc_next = 15'h300; phase_next = PH_ESC2;
                end
                else
                begin
                    do_op = 1'b1; op = {2'd1, b};
                end
            end
            PH_ESC2:
            begin
                do_op = 1'b1; op = {opc_reg[9:8], b};
            end
            PH_MODRM:
            begin
                mod_next = b[7:6];
                if (prop_reg.group)
                begin
                    if (b[5:3] <= 3'd1)
                    begin
                        if (opc_reg == 15'h0f6) prop_next.imm8 = 1'b1;
                        else if (opc_reg == 15'h0f7) prop_next.imm = 1'b1;
                    end
                    racc_next = 24'hff0000;
                    opc_next = {b[5:3], opc_reg[11:0]};
                end
                else racc_next = {4'd0, rex_reg[2], b[5:3], 16'd0};
                if (prop_reg.rcx) racc_next = 24'h010000;
                if (b[7:6] == 2'd3)
                begin
                    racc_next[7:0] = {4'd0, rex_reg[0], b[2:0]};
                    go_imm = 1'b1;
                end
                else
                begin
                    ind_next = 1'b1;
                    if (b[2:0] == 3'd4) phase_next = PH_SIB;
                    else if (b[7:6] == 2'd0 && b[2:0] == 3'd5)
                    begin
                        racc_next[15:0] = 16'hffff;
                        go_disp = 1'b1; dn = 4'd4;
                    end
                    else
                    begin
                        racc_next[15:0] = {8'hff, 4'd0, rex_reg[0], b[2:0]};
                        go_disp = 1'b1;
                        dn = (b[7:6] == 2'd1) ? 4'd1 : ((b[7:6] == 2'd2) ? 4'd4 : 4'd0);
                    end
                end
            end
            PH_SIB:
            begin
                idx = {1'b0, rex_reg[1], b[5:3]};
                if (idx == 5'd4) idx = 5'h1f;
                if (mod_reg == 2'd0 && b[2:0] == 3'd5) base = 8'hff;
                else base = {4'd0, rex_reg[0], b[2:0]};
                scale_next = b[7:6];
                racc_next = racc_reg | {8'd0, (idx == 5'h1f) ? 8'hff : {3'd0, idx}, base};
                go_disp = 1'b1;
                dn = (mod_reg == 2'd1) ? 4'd1 :
                     ((mod_reg == 2'd2 || base == 8'hff) ? 4'd4 : 4'd0);
            end
            PH_DISP:
            begin
                sh = {1'b0, 2'(fsize_reg - left_reg)};
                disp_next = disp_reg | (32'(b) << {sh[1:0], 3'd0});
                if (left_reg != 4'd0) left_next = left_reg - 4'd1;
                if (left_next == 4'd0)
                begin
                    if (fsize_reg == 4'd1) disp_next = {{24{disp_next[7]}}, disp_next[7:0]};
                    go_imm = 1'b1;
                end
            end
            PH_IMM:
            begin
                sh = 3'(fsize_reg - left_reg);
                imm_next = imm_reg | (64'(b) << {sh, 3'd0});
                if (left_reg != 4'd0) left_next = left_reg - 4'd1;
                if (left_next == 4'd0)
                begin
                    unique case (fsize_reg)
                        4'd1: imm_fin = {{56{imm_next[7]}}, imm_next[7:0]};
                        4'd2: imm_fin = {{48{imm_next[15]}}, imm_next[15:0]};
                        4'd4: imm_fin = {{32{imm_next[31]}}, imm_next[31:0]};
                        default: imm_fin = imm_next;
                    endcase
                    imm_next = imm_fin;
                    fire = 1'b1;
                end
            end
            default: ;
        endcase

        if (do_op)
        begin
            opc_next = {5'd0, op};
            p = rom(op);
            if (p == '0) err = 1'b1;
            else
            begin
                prop_next = p;
                if (p.sse)
                begin
                    if (pflags_reg[2]) otype_next = DT_F64X1;
                    else if (pflags_reg[1]) otype_next = DT_F32X1;
                    else if (otype_reg == DT_WORD) otype_next = p.scalar ? DT_F64X1 : DT_F64X2;
                    else otype_next = p.scalar ? DT_F32X1 : DT_F32X4;
                    pflags_next = {2'd0, pflags_reg[0]};
                end
                else if (p.is64) otype_next = DT_QWORD;
                else if (p.is8) otype_next = DT_BYTE;
                else if (rex_reg[3]) otype_next = DT_QWORD;
                if (p.modrm) phase_next = PH_MODRM;
                else
                begin
                    if (p.rax) racc_next = 24'hffff00;
                    else if (p.plusr)
                    begin
                        racc_next = {16'hffff, 4'd0, rex_reg[0], op[2:0]};
                        opc_next = {5'd0, op[9:3], 3'd0};
                    end
                    else racc_next = 24'hffffff;
                    go_imm = 1'b1;
                end
            end
        end

        if (go_disp)
        begin
            disp_next = 32'd0;
            if (dn == 4'd0) go_imm = 1'b1;
            else
            begin
                dpos_next = cnt; fsize_next = dn; left_next = dn; phase_next = PH_DISP;
            end
        end

        isz = 4'd0;
        if (go_imm)
        begin
            if (prop_next.imm8) isz = 4'd1;
            else if (prop_next.imm)
            begin
                unique case (otype_next)
                    DT_BYTE:  isz = 4'd1;
                    DT_WORD:  isz = 4'd2;
                    DT_QWORD: isz = (opc_next >= 15'h0b8 && opc_next <= 15'h0bf) ? 4'd8 : 4'd4;
                    default:  isz = 4'd4;
                endcase
            end
            if (isz == 4'd0) fire = 1'b1;
            else
            begin
                hasimm_next = 1'b1; fsize_next = isz; left_next = isz;
                imm_next = 64'd0; phase_next = PH_IMM;
            end
        end
    end

    assign clr = fire || err;
    assign disp_cur = disp_next;

    always_comb
    begin
        dt2 = otype_next;
        if (prop_next.twodt)
        begin
            if (opc_next == 15'h1b6 || opc_next == 15'h1be) dt2 = DT_BYTE;
            else if (opc_next == 15'h1b7 || opc_next == 15'h1bf) dt2 = DT_WORD;
            else dt2 = DT_DWORD;
        end
        res = '0;
        res.inst_length = cnt;
        if (err)
        begin
            res.status = 1'b1;
            res.ext_opcode = {5'd0, op};
        end
        else
        begin
            res.ext_opcode = opc_next;
            res.data_type = otype_next;
            res.second_type = dt2;
            res.reg_fields = racc_next;
            res.scale_log2 = scale_next;
            res.displacement = disp_cur;
            res.disp_offset = dpos_next;
            res.immediate = imm_next;
            res.inst_flags = {prop_next.dir, hasimm_next, ind_next, pflags_next};
            res.segment = seg_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (take)
        begin
            out_v_reg <= clr;
        end
        else if (m_tready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && clr) out_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PREFIX; pflags_reg <= '0; otype_reg <= DT_DWORD; seg_reg <= '0;
            rex_reg <= '0; opc_reg <= '0; prop_reg <= '0; mod_reg <= '0; racc_reg <= '0;
            disp_reg <= '0; imm_reg <= '0; left_reg <= '0; fsize_reg <= '0; cnt_reg <= '0;
            dpos_reg <= '0; scale_reg <= '0; ind_reg <= 1'b0; hasimm_reg <= 1'b0;
        end
        else if (take)
        begin
            if (clr)
            begin
                phase_reg <= PH_PREFIX; pflags_reg <= '0; otype_reg <= DT_DWORD;
                seg_reg <= '0; rex_reg <= '0; opc_reg <= '0; prop_reg <= '0;
                mod_reg <= '0; racc_reg <= '0; disp_reg <= '0; imm_reg <= '0;
                left_reg <= '0; fsize_reg <= '0; cnt_reg <= '0; dpos_reg <= '0;
                scale_reg <= '0; ind_reg <= 1'b0; hasimm_reg <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next; pflags_reg <= pflags_next; otype_reg <= otype_next;
                seg_reg <= seg_next; rex_reg <= rex_next; opc_reg <= opc_next;
                prop_reg <= prop_next; mod_reg <= mod_next; racc_reg <= racc_next;
                disp_reg <= disp_next; imm_reg <= imm_next; left_reg <= left_next;
                fsize_reg <= fsize_next; cnt_reg <= cnt; dpos_reg <= dpos_next;
                scale_reg <= scale_next; ind_reg <= ind_next; hasimm_reg <= hasimm_next;
            end
        end
    end

endmodule

### tb/x86_64_instruction_decoder_top_tb.sv
module x86_64_instruction_decoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import x86d_pkg::*;

    localparam int LIMIT_CYCLES = 200000;

    // property bits of the opcode map
    localparam int P_MODRM  = 14'h0001;
    localparam int P_DIR    = 14'h0002;
    localparam int P_IMM    = 14'h0004;
    localparam int P_IMM8   = 14'h0008;
    localparam int P_8BIT   = 14'h0010;
    localparam int P_64BIT  = 14'h0020;
    localparam int P_PLUSR  = 14'h0040;
    localparam int P_GROUP  = 14'h0080;
    localparam int P_NOARG  = 14'h0100;
    localparam int P_TWODT  = 14'h0200;
    localparam int P_RCX    = 14'h0400;
    localparam int P_RAX    = 14'h0800;
    localparam int P_SSE    = 14'h1000;
    localparam int P_SCALAR = 14'h2000;

    localparam logic [2:0] PF_LOCK  = 3'b001;
    localparam logic [2:0] PF_REP   = 3'b010;
    localparam logic [2:0] PF_REPNE = 3'b100;

    typedef struct {
        logic        status;
        logic [14:0] ext_opcode;
        logic [2:0]  data_type;
        logic [2:0]  second_type;
        logic [23:0] reg_fields;
        logic [1:0]  scale_log2;
        logic [31:0] displacement;
        logic [5:0]  disp_offset;
        logic [63:0] immediate;
        logic [5:0]  inst_flags;
        logic [2:0]  segment;
        logic [5:0]  inst_length;
    } decoded_t;

    class decode_scoreboard;
        logic [2:0]  phase;
        logic [2:0]  pfx;
        logic [2:0]  optype;
        logic [2:0]  seg;
        logic [7:0]  rex;
        logic [14:0] opc;
        int          props;
        logic [7:0]  modrm;
        logic [23:0] regs;
        logic [31:0] disp;
        logic [63:0] imm;
        int          left;
        int          fsize;
        logic [5:0]  count;
        logic [5:0]  dpos;
        logic [1:0]  scale;
        bit          indir;
        bit          has_imm;
        decoded_t    res;
        decoded_t    pending[$];
        int          errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            phase = PH_PREFIX; pfx = 0; optype = DT_DWORD; seg = SEG_NONE; rex = 0;
            opc = 0; props = 0; modrm = 0; regs = 0; disp = 0; imm = 0; left = 0;
            fsize = 0; count = 0; dpos = 0; scale = 0; indir = 0; has_imm = 0;
        endfunction

        function int opcode_props(logic [9:0] op);
            logic [7:0] o;
            o = op[7:0];
            if (op[9:8] == 2'd0) begin
                if (o < 8'h40 && o[7:3] != 5'd3) begin
                    case (o[2:0])
                        3'd0: return P_MODRM | P_8BIT;
                        3'd1: return P_MODRM;
                        3'd2: return P_MODRM | P_DIR | P_8BIT;
                        3'd3: return P_MODRM | P_DIR;
                        3'd4: return P_RAX | P_IMM8;
                        3'd5: return P_RAX | P_IMM;
                        default: return 0;
                    endcase
                end
                if (o >= 8'h50 && o <= 8'h5f) return P_PLUSR | P_64BIT;
                if (o >= 8'h70 && o <= 8'h7f) return P_IMM8;
                if (o >= 8'hb0 && o <= 8'hb7) return P_PLUSR | P_IMM | P_8BIT;
                if (o >= 8'hb8 && o <= 8'hbf) return P_PLUSR | P_IMM;
                case (o)
                    8'h88, 8'h84: return P_MODRM | P_8BIT;
                    8'h89, 8'h85: return P_MODRM;
                    8'h8a: return P_MODRM | P_DIR | P_8BIT;
                    8'h8b, 8'h8d: return P_MODRM | P_DIR;
                    8'h63: return P_MODRM | P_DIR | P_TWODT;
                    8'h69: return P_MODRM | P_DIR | P_IMM;
                    8'h80, 8'hc6: return P_MODRM | P_IMM | P_8BIT | P_GROUP;
                    8'h81, 8'hc7: return P_MODRM | P_IMM | P_GROUP;
                    8'h83, 8'hc1: return P_MODRM | P_IMM8 | P_GROUP;
                    8'hc0: return P_MODRM | P_IMM8 | P_GROUP | P_8BIT;
                    8'h90, 8'h98, 8'h99, 8'hc3, 8'h9c, 8'h9d, 8'ha4, 8'ha5, 8'haa,
                    8'hab, 8'hae, 8'haf, 8'hcc: return P_NOARG;
                    8'hd0, 8'hf6: return P_MODRM | P_GROUP | P_8BIT;
                    8'hd1, 8'hf7, 8'hfe, 8'hff: return P_MODRM | P_GROUP;
                    8'hd2: return P_MODRM | P_RCX | P_GROUP | P_8BIT;
                    8'hd3: return P_MODRM | P_RCX | P_GROUP;
                    8'he8, 8'he9: return P_IMM;
                    8'heb: return P_IMM8;
                    default: return 0;
                endcase
            end
            if (op[9:8] == 2'd1) begin
                if (o >= 8'hc8 && o <= 8'hcf) return P_PLUSR;
                if (o >= 8'h40 && o <= 8'h4f) return P_MODRM | P_DIR;
                if (o >= 8'h51 && o <= 8'h5f) return P_MODRM | P_DIR | P_SSE;
                if (o >= 8'h80 && o <= 8'h8f) return P_IMM;
                if (o >= 8'h90 && o <= 8'h9f) return P_MODRM | P_GROUP;
                case (o)
                    8'h05, 8'h0b: return P_NOARG;
                    8'h10: return P_MODRM | P_SSE | P_DIR;
                    8'h11: return P_MODRM | P_SSE;
                    8'h1f, 8'ha3, 8'haf: return P_MODRM;
                    8'h2e: return P_MODRM | P_SSE | P_DIR | P_SCALAR;
                    8'hc6: return P_MODRM | P_SSE | P_DIR | P_IMM8;
                    8'hb6, 8'hb7, 8'hbe, 8'hbf: return P_MODRM | P_TWODT | P_DIR;
                    default: return 0;
                endcase
            end
            return 0;
        endfunction

        function bit emit();
            logic [2:0] dt2;
            dt2 = optype;
            if (props & P_TWODT) begin
                if (opc == 15'h1b6 || opc == 15'h1be) dt2 = DT_BYTE;
                else if (opc == 15'h1b7 || opc == 15'h1bf) dt2 = DT_WORD;
                else dt2 = DT_DWORD;
            end
            res.status = 0; res.ext_opcode = opc; res.data_type = optype;
            res.second_type = dt2; res.reg_fields = regs; res.scale_log2 = scale;
            res.displacement = disp; res.disp_offset = dpos; res.immediate = imm;
            res.inst_flags = {((props & P_DIR) != 0), has_imm, indir, pfx};
            res.segment = seg; res.inst_length = count;
            clear();
            return 1;
        endfunction

        function bit emit_unknown();
            res = '{default: '0};
            res.status = 1;
            res.ext_opcode = {5'd0, opc[9:0]};
            res.inst_length = count;
            clear();
            return 1;
        endfunction

        function bit start_imm();
            int size;
            size = 0;
            if (props & P_IMM8) size = 1;
            else if (props & P_IMM) begin
                size = (optype <= DT_QWORD) ? (1 << optype) : 4;
                if (size > 4 && (opc < 15'hb8 || opc > 15'hbf)) size = 4;
            end
            if (size == 0) return emit();
            has_imm = 1; fsize = size; left = size; imm = 0; phase = PH_IMM;
            return 0;
        endfunction

        function bit start_disp(int n);
            disp = 0;
            if (n == 0) return start_imm();
            dpos = count; fsize = n; left = n; phase = PH_DISP;
            return 0;
        endfunction

        function bit finish_opcode(logic [9:0] op);
            int p;
            opc = {5'd0, op};
            p = opcode_props(op);
            if (p == 0) return emit_unknown();
            props = p;
            if (p & P_SSE) begin
                if (pfx & PF_REPNE) optype = DT_F64X1;
                else if (pfx & PF_REP) optype = DT_F32X1;
                else if (optype == DT_WORD) optype = (p & P_SCALAR) ? DT_F64X1 : DT_F64X2;
                else optype = (p & P_SCALAR) ? DT_F32X1 : DT_F32X4;
                pfx = pfx & PF_LOCK;
            end else if (p & P_64BIT) optype = DT_QWORD;
            else if (p & P_8BIT) optype = DT_BYTE;
            else if (rex[3]) optype = DT_QWORD;
            if (p & P_MODRM) begin
                phase = PH_MODRM;
                return 0;
            end
            if (p & P_RAX) regs = 24'hffff00;
            else if (p & P_PLUSR) begin
                regs = {16'hffff, 4'd0, rex[0], opc[2:0]};
                opc[2:0] = 3'd0;
            end else regs = 24'hffffff;
            return start_imm();
        endfunction

        function bit take_modrm(logic [7:0] b);
            logic [1:0] md;
            logic [2:0] rx;
            logic [2:0] rm;
            md = b[7:6]; rx = b[5:3]; rm = b[2:0];
            modrm = b;
            if (props & P_GROUP) begin
                if (rx <= 3'd1) begin
                    if (opc == 15'hf6) props = props | P_IMM8;
                    else if (opc == 15'hf7) props = props | P_IMM;
                end
                regs = 24'hff0000;
                opc[14:12] = rx;
            end else regs = {4'd0, rex[2], rx, 16'd0};
            if (props & P_RCX) regs = 24'h010000;
            if (md == 2'd3) begin
                regs[7:0] = {4'd0, rex[0], rm};
                return start_imm();
            end
            indir = 1;
            if (rm == 3'd4) begin
                phase = PH_SIB;
                return 0;
            end
            if (md == 2'd0 && rm == 3'd5) begin
                regs[15:0] = 16'hffff;
                return start_disp(4);
            end
            regs[15:0] = {8'hff, 4'd0, rex[0], rm};
            return start_disp(md == 2'd1 ? 1 : (md == 2'd2 ? 4 : 0));
        endfunction

        function bit take_sib(logic [7:0] b);
            logic [1:0] md;
            logic [3:0] idx;
            bit         nobase;
            md = modrm[7:6];
            idx = {rex[1], b[5:3]};
            nobase = (md == 2'd0 && b[2:0] == 3'd5);
            scale = b[7:6];
            regs[15:8] = (idx == 4'd4) ? 8'hff : {4'd0, idx};
            regs[7:0] = nobase ? 8'hff : {4'd0, rex[0], b[2:0]};
            return start_disp(md == 2'd1 ? 1 : ((md == 2'd2 || nobase) ? 4 : 0));
        endfunction

        function bit step(logic [7:0] b);
            if (count < 6'd63) count = count + 6'd1;
            case (phase)
                PH_PREFIX:
                begin
                    case (b)
                        8'hf0: begin pfx = pfx | PF_LOCK;  return 0; end
                        8'hf3: begin pfx = pfx | PF_REP;   return 0; end
                        8'hf2: begin pfx = pfx | PF_REPNE; return 0; end
                        8'h66: begin optype = DT_WORD; return 0; end
                        8'h67: return 0;
                        8'h2e: begin seg = SEG_CS; return 0; end
                        8'h36: begin seg = SEG_SS; return 0; end
                        8'h3e: begin seg = SEG_DS; return 0; end
                        8'h26: begin seg = SEG_ES; return 0; end
                        8'h64: begin seg = SEG_FS; return 0; end
                        8'h65: begin seg = SEG_GS; return 0; end
                        default: ;
                    endcase
                    if (b[7:4] == 4'h4) begin
                        rex = b;
                        phase = PH_OPC;
                        return 0;
                    end
                    if (b == 8'h0f) begin
                        phase = PH_ESC;
                        return 0;
                    end
                    return finish_opcode({2'd0, b});
                end
                PH_OPC:
                begin
                    if (b == 8'h0f) begin
                        phase = PH_ESC;
                        return 0;
                    end
                    return finish_opcode({2'd0, b});
                end
                PH_ESC:
                begin
                    if (b == 8'h38 || b == 8'h3a) begin
                        opc = (b == 8'h38) ? 15'h200 : 15'h300;
                        phase = PH_ESC2;
                        return 0;
                    end
                    return finish_opcode({2'd1, b});
                end
                PH_ESC2: return finish_opcode({opc[9:8], b});
                PH_MODRM: return take_modrm(b);
                PH_SIB: return take_sib(b);
                PH_DISP:
                begin
                    disp = disp | (32'(b) << (8 * ((fsize - left) & 3)));
                    if (left > 0) left--;
                    if (left != 0) return 0;
                    if (fsize == 1) disp = {{24{disp[7]}}, disp[7:0]};
                    return start_imm();
                end
                default:
                begin
                    imm = imm | (64'(b) << (8 * ((fsize - left) & 7)));
                    if (left > 0) left--;
                    if (left != 0) return 0;
                    case (fsize)
                        1: imm = {{56{imm[7]}}, imm[7:0]};
                        2: imm = {{48{imm[15]}}, imm[15:0]};
                        4: imm = {{32{imm[31]}}, imm[31:0]};
                        default: ;
                    endcase
                    return emit();
                end
            endcase
        endfunction

        function void note_byte(logic [7:0] b);
            if (step(b)) pending.push_back(res);
        endfunction

        function void cmp(string name, logic [63:0] e, logic [63:0] a);
            if (e !== a) begin
                $error("%s expected %0h got %0h", name, e, a);
                errors++;
            end
        endfunction

        function void check_word(logic [167:0] d);
            decoded_t e;
            if (pending.size() == 0) begin
                $error("result word with nothing expected: %0h", d);
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("status", e.status, d[0]);
            cmp("ext_opcode", e.ext_opcode, d[15:1]);
            cmp("data_type", e.data_type, d[18:16]);
            cmp("second_type", e.second_type, d[21:19]);
            cmp("reg_fields", e.reg_fields, d[45:22]);
            cmp("scale_log2", e.scale_log2, d[47:46]);
            cmp("displacement", e.displacement, d[79:48]);
            cmp("disp_offset", e.disp_offset, d[85:80]);
            cmp("immediate", e.immediate, d[149:86]);
            cmp("inst_flags", e.inst_flags, d[155:150]);
            cmp("segment", e.segment, d[158:156]);
            cmp("inst_length", e.inst_length, d[164:159]);
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [167:0] m_tdata;

    decode_scoreboard sb;
    decode_scoreboard lookahead;
    logic [7:0]       byte_stream[$];
    int               send_idle;
    int               recv_idle;
    int               hold_left;
    int               cycles;

    x86_64_instruction_decoder_top DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT_CYCLES) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function void push_byte(logic [7:0] b);
        byte_stream.push_back(b);
        void'(lookahead.step(b));
    endfunction

    function void push_seq(logic [7:0] s[]);
        foreach (s[i]) push_byte(s[i]);
    endfunction

    function void add_instruction();
        logic [7:0] prefixes[12] = '{8'hf0, 8'hf3, 8'hf2, 8'h66, 8'h67, 8'h2e, 8'h36,
                                     8'h3e, 8'h26, 8'h64, 8'h65, 8'h66};
        logic [7:0] plain_ops[] = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h29,
                                    8'h3b, 8'h50, 8'h57, 8'h63, 8'h69, 8'h74, 8'h80,
                                    8'h81, 8'h83, 8'h84, 8'h85, 8'h88, 8'h89, 8'h8a,
                                    8'h8b, 8'h8d, 8'h90, 8'h98, 8'ha4, 8'hb0, 8'hb8,
                                    8'hbf, 8'hc0, 8'hc1, 8'hc3, 8'hc6, 8'hc7, 8'hcc,
                                    8'hd0, 8'hd2, 8'hd3, 8'he8, 8'he9, 8'heb, 8'hf6,
                                    8'hf7, 8'hfe, 8'hff};
        logic [7:0] esc_ops[] = '{8'h05, 8'h10, 8'h11, 8'h1f, 8'h2e, 8'h44, 8'h51,
                                  8'h58, 8'h84, 8'h94, 8'ha3, 8'haf, 8'hb6, 8'hb7,
                                  8'hbe, 8'hbf, 8'hc6, 8'hc8, 8'hcf, 8'h0b};
        int r;
        int k;
        bit done;
        for (k = $urandom_range(0, 2); k > 0; k--)
            push_byte(prefixes[$urandom_range(0, 11)]);
        if ($urandom_range(0, 1)) push_byte({4'h4, 4'($urandom_range(0, 15))});
        r = $urandom_range(0, 99);
        if (r < 60) push_byte(plain_ops[$urandom_range(0, plain_ops.size() - 1)]);
        else if (r < 85) push_seq('{8'h0f, esc_ops[$urandom_range(0, esc_ops.size() - 1)]});
        else if (r < 90) push_seq('{8'h0f, ($urandom_range(0, 1) ? 8'h38 : 8'h3a)});
        else push_byte(8'($urandom_range(0, 255)));
        done = (lookahead.phase == PH_PREFIX && lookahead.count == 0);
        while (!done)
        begin
            push_byte(8'($urandom_range(0, 255)));
            done = (lookahead.phase == PH_PREFIX && lookahead.count == 0);
        end
    endfunction

    task automatic send_byte(logic [7:0] b);
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_byte(b);
    endtask

    // receiver side, with a long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (m_tvalid && m_tready) sb.check_word(m_tdata);
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    initial
    begin
        int total;
        int i;
        sb = new();
        lookahead = new();
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = 0;
        m_tready = 0;
        hold_left = 0;
        send_idle = 18;
        recv_idle = 78;

        // movabs, test immediates, shift by cl, sib forms, rip-relative
        push_seq('{8'h48, 8'hb8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80});
        push_seq('{8'hf6, 8'hc0, 8'h7f});
        push_seq('{8'h66, 8'hf7, 8'hc9, 8'h00, 8'h80});
        push_seq('{8'hd3, 8'he0});
        push_seq('{8'h8b, 8'h04, 8'h25, 8'h78, 8'h56, 8'h34, 8'h12});
        push_seq('{8'h8b, 8'h05, 8'hff, 8'hff, 8'hff, 8'hff});
        push_seq('{8'h8b, 8'h44, 8'h24, 8'h80});
        push_seq('{8'h4f, 8'h8b, 8'h84, 8'he4, 8'h00, 8'h00, 8'h00, 8'h80});
        // sse types
        push_seq('{8'h66, 8'hf2, 8'h0f, 8'h58, 8'hc1});
        push_seq('{8'hf3, 8'h0f, 8'h10, 8'h00});
        push_seq('{8'h66, 8'h0f, 8'h2e, 8'hc0});
        push_seq('{8'h0f, 8'h51, 8'hc0});
        push_seq('{8'h0f, 8'hc6, 8'hc0, 8'hff});
        // widening moves
        push_seq('{8'h48, 8'h0f, 8'hb6, 8'hc0});
        push_seq('{8'h0f, 8'hbf, 8'hc0});
        push_seq('{8'h48, 8'h63, 8'hc0});
        // lock, all segments, address size
        push_seq('{8'hf0, 8'h2e, 8'h36, 8'h3e, 8'h26, 8'h64, 8'h65, 8'h67, 8'h01, 8'h00});
        // prefix after rex, unknown maps and opcodes
        push_seq('{8'h48, 8'h66});
        push_seq('{8'h0f, 8'h38, 8'h00, 8'h0f, 8'h3a, 8'hff, 8'h06});
        push_seq('{8'he8, 8'h00, 8'h00, 8'h00, 8'h80, 8'heb, 8'h80, 8'h05, 8'hff, 8'hff,
                   8'hff, 8'h7f, 8'h04, 8'hff});
        push_seq('{8'hc1, 8'he0, 8'hff, 8'h69, 8'hc0, 8'h01, 8'h00, 8'h00, 8'h00, 8'h50,
                   8'h41, 8'h5f, 8'h0f, 8'hc8, 8'h0f, 8'h05, 8'hc3});
        // saturating length and displacement offset
        repeat (70) push_byte(8'h66);
        push_byte(8'h90);
        repeat (62) push_byte(8'h66);
        push_seq('{8'h8b, 8'h80, 8'h01, 8'h02, 8'h03, 8'h04});
        while (byte_stream.size() < 450) add_instruction();
        total = byte_stream.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < total; i++)
        begin
            if (i == total / 3) begin
                send_idle = 78;
                recv_idle = 18;
            end
            if (i == (2 * total) / 3) begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (i == total / 2) hold_left = 300;
            if (i == (5 * total) / 6) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (sb.pending.size() != 0) @(posedge clk);
            end
            if ($urandom_range(0, 99) < send_idle) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            send_byte(byte_stream[i]);
        end
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
